// File: rtl/core/cbd_pkg.sv
// Package for the chunked body decoder.
// Holds phase and status codes, the character constants and the shared types.
// No dependencies.
package cbd_pkg;

	localparam logic [2:0] PH_SIZE    = 3'd0;
	localparam logic [2:0] PH_SIZE_LF = 3'd1;
	localparam logic [2:0] PH_DATA    = 3'd2;
	localparam logic [2:0] PH_DATA_CR = 3'd3;
	localparam logic [2:0] PH_DATA_LF = 3'd4;
	localparam logic [2:0] PH_LAST_CR = 3'd5;
	localparam logic [2:0] PH_LAST_LF = 3'd6;

	localparam logic [1:0] ST_INCOMPLETE = 2'd0;
	localparam logic [1:0] ST_DONE       = 2'd1;
	localparam logic [1:0] ST_BAD        = 2'd2;
	localparam logic [1:0] ST_LARGE      = 2'd3;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// One hex digit carries this many bits of the chunk size.
	localparam int HEX_BITS = 4;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic [1:0] status;
	} cbd_result_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [1:0] final_status;
		logic       over_limit;
	} cbd_state_t;

	// Returns {is_hex, value}.
	function automatic logic [HEX_BITS:0] hex_value(input logic [7:0] c);
		logic [HEX_BITS:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// File: rtl/core/cbd_if.sv
// Stream and configuration interfaces of the chunked body decoder.
// Depends on nothing but plain logic types.
interface cbd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       restart;
	modport source (output valid, output byte_in, output restart, input ready);
	modport sink (input valid, input byte_in, input restart, output ready);
endinterface

interface cbd_result_if;
	logic       valid;
	logic       ready;
	logic       data_valid;
	logic [7:0] data_byte;
	logic [1:0] status;
	modport source (output valid, output data_valid, output data_byte, output status,
		input ready);
	modport sink (input valid, input data_valid, input data_byte, input status,
		output ready);
endinterface

interface cbd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/cbd_parser.sv
// Parser state and per-byte next-state logic of the chunked body decoder.
// Depends on cbd_pkg.
module cbd_parser #(
	parameter int SIZE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          byte_in,
	input  logic                restart,
	input  logic [31:0]         max_body_size,
	output cbd_pkg::cbd_result_t result,
	output cbd_pkg::cbd_state_t  state
);
	import cbd_pkg::*;

	localparam int CW = (SIZE_BITS > 32) ? SIZE_BITS : 32;

	logic [2:0]           phase_q;
	logic [SIZE_BITS-1:0] chunk_q;
	logic [31:0]          body_q;
	logic [1:0]           fs_q;
	logic                 ol_q;
	logic                 sd_q;

	logic [2:0]           phase_c, phase_n;
	logic [SIZE_BITS-1:0] chunk_c, chunk_n;
	logic [31:0]          body_c, body_n;
	logic [1:0]           fs_c, fs_n;
	logic                 ol_c, ol_n;
	logic                 sd_c, sd_n;

	logic [HEX_BITS:0] hv;
	logic [31:0]       room;
	logic [CW-1:0]     chunk_x;
	logic [CW-1:0]     room_x;
	logic              limit_hit;
	logic              valid_n;

	always_comb begin
		// A restart clears everything but the limit register before the byte is used.
		phase_c = restart ? PH_SIZE : phase_q;
		chunk_c = restart ? '0 : chunk_q;
		body_c  = restart ? '0 : body_q;
		fs_c    = restart ? ST_INCOMPLETE : fs_q;
		ol_c    = restart ? 1'b0 : ol_q;
		sd_c    = restart ? 1'b0 : sd_q;

		hv        = hex_value(byte_in);
		room      = max_body_size - body_c;
		chunk_x   = CW'(chunk_c);
		room_x    = CW'(room);
		limit_hit = (max_body_size != 32'd0) &&
			((body_c > max_body_size) || (chunk_x > room_x));

		phase_n = phase_c;
		chunk_n = chunk_c;
		body_n  = body_c;
		fs_n    = fs_c;
		ol_n    = ol_c;
		sd_n    = sd_c;
		valid_n = 1'b0;

		if (fs_c == ST_INCOMPLETE) begin
			case (phase_c)
				PH_SIZE: begin
					if (hv[HEX_BITS]) begin
						if (chunk_c[SIZE_BITS-1 -: HEX_BITS] != '0) begin
							fs_n = ST_BAD;
						end else begin
							chunk_n = {chunk_c[SIZE_BITS-HEX_BITS-1:0], hv[HEX_BITS-1:0]};
							sd_n    = 1'b1;
						end
					end else if (byte_in == CH_CR && sd_c) begin
						phase_n = PH_SIZE_LF;
					end else begin
						fs_n = ST_BAD;
					end
				end
				PH_SIZE_LF: begin
					if (byte_in != CH_LF) begin
						fs_n = ST_BAD;
					end else if (chunk_c == '0) begin
						phase_n = PH_LAST_CR;
					end else begin
						ol_n    = limit_hit;
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					if (!ol_c) begin
						valid_n = 1'b1;
						if (body_c != '1) begin
							body_n = body_c + 32'd1;
						end
					end
					chunk_n = chunk_c - SIZE_BITS'(1);
					if (chunk_c == SIZE_BITS'(1)) begin
						phase_n = PH_DATA_CR;
					end
				end
				PH_DATA_CR: begin
					if (byte_in == CH_CR) begin
						phase_n = PH_DATA_LF;
					end else begin
						fs_n = ST_BAD;
					end
				end
				PH_DATA_LF: begin
					if (byte_in != CH_LF) begin
						fs_n = ST_BAD;
					end else if (ol_c) begin
						fs_n = ST_LARGE;
					end else begin
						phase_n = PH_SIZE;
						chunk_n = '0;
						sd_n    = 1'b0;
					end
				end
				PH_LAST_CR: begin
					if (byte_in == CH_CR) begin
						phase_n = PH_LAST_LF;
					end else begin
						fs_n = ST_BAD;
					end
				end
				PH_LAST_LF: begin
					fs_n = (byte_in == CH_LF) ? ST_DONE : ST_BAD;
				end
				default: begin
					fs_n = ST_BAD;
				end
			endcase
		end

		result.data_valid = valid_n;
		result.data_byte  = valid_n ? byte_in : 8'd0;
		result.status     = fs_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			chunk_q <= '0;
			body_q  <= '0;
			fs_q    <= ST_INCOMPLETE;
			ol_q    <= 1'b0;
			sd_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			chunk_q <= chunk_n;
			body_q  <= body_n;
			fs_q    <= fs_n;
			ol_q    <= ol_n;
			sd_q    <= sd_n;
		end
	end

	assign state.phase        = phase_q;
	assign state.final_status = fs_q;
	assign state.over_limit   = ol_q;

endmodule

// File: rtl/core/chunked_body_decoder.sv
// Chunked body decoder: one raw byte in, one result item out for every byte.
// An accepted byte's result is registered and valid in the next cycle.
// One byte per cycle unless result_ch stalls; the output refills while it is taken.
// Asynchronous reset clears the parser to the start of a size line, status to
// incomplete and the body limit to zero (no limit). There is no clearing pass.
module chunked_body_decoder #(
	parameter int SIZE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	cbd_byte_if.sink     byte_ch,
	cbd_result_if.source result_ch,
	cbd_cfg_if.sink      cfg
);
	import cbd_pkg::*;

	logic        accept;
	logic [31:0] max_q;
	logic        out_valid_q;
	cbd_result_t res_c;
	cbd_result_t res_q;
	cbd_state_t  st;

	assign byte_ch.ready = !out_valid_q || result_ch.ready;
	assign accept        = byte_ch.valid && byte_ch.ready;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (cfg.valid) begin
			max_q <= cfg.data;
		end
	end

	cbd_parser #(
		.SIZE_BITS(SIZE_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.byte_in      (byte_ch.byte_in),
		.restart      (byte_ch.restart),
		.max_body_size(max_q),
		.result       (res_c),
		.state        (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_c;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.data_valid = res_q.data_valid;
	assign result_ch.data_byte  = res_q.data_byte;
	assign result_ch.status     = res_q.status;

`ifndef NO_ASSERTIONS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_ch.valid)
		else $error("accepted byte did not produce a result");

	a_sticky_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !byte_ch.restart && st.final_status != ST_INCOMPLETE
		|=> st.final_status == $past(st.final_status)
			&& result_ch.status == $past(st.final_status))
		else $error("final status changed without restart");

	a_data_only_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.data_valid |-> result_ch.status == ST_INCOMPLETE)
		else $error("data byte delivered with a final status");

	a_large_after_crlf: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !byte_ch.restart && st.final_status == ST_INCOMPLETE
			&& st.phase == PH_DATA_LF && st.over_limit && byte_ch.byte_in == CH_LF
		|=> st.final_status == ST_LARGE)
		else $error("oversized chunk did not report too large");
`endif

endmodule
